// ===== hw/rtl/rle_sprite_blitter_defines.svh =====
// ----------------------------------------------------------------------------
// rle_sprite_blitter_defines: assertion macros
// Shared concurrent assertion macros for the sprite blitter RTL. They expand
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RLE_SPRITE_BLITTER_DEFINES_SVH
`define RLE_SPRITE_BLITTER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define RSB_ASSERT(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("rsb assertion failed");

// Check a consequent in the same cycle as its antecedent
`define RSB_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rsb implication failed");

// Check a consequent in the cycle after its antecedent
`define RSB_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rsb next-cycle check failed");

`else

`define RSB_ASSERT(name, clk, rstn, expr)
`define RSB_ASSERT_IMP(name, clk, rstn, ante, cons)
`define RSB_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/rsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rsb_pkg: sprite blitter package
// Beat types, configuration record, parser phases and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsb_pkg;

  // Field and address widths
  localparam int unsigned FRAME_ADDR_BITS_DEF = 19;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;
  localparam int unsigned RUN_COUNT_BITS      = 12;
  localparam int unsigned ADDR_BITS           = 24;
  localparam int unsigned OUT_ADDR_BITS       = 19;
  localparam int unsigned CFG_DATA_BITS       = 13;
  localparam int unsigned CFG_INDEX_BITS      = 2;

  localparam logic [ADDR_BITS-1:0] ADDR_SAT          = {ADDR_BITS{1'b1}};
  localparam logic [12:0]          LINE_STRIDE_RESET = 13'd640;

  // Header and control word bits
  localparam int unsigned HDR_RLE_BIT = 0;
  localparam int unsigned HDR_OFS_BIT = 1;
  localparam int unsigned CTL_RUN_BIT = 15;
  localparam int unsigned CTL_EOL_BIT = 14;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRANSPARENT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_ROW    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_COLUMN = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_STRIDE = 2'd3;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_NONE  = 2'd2
  } rsb_kind_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HDR_HI,
    PH_ROFF_LO,
    PH_ROFF_HI,
    PH_COFF_LO,
    PH_COFF_HI,
    PH_W_LO,
    PH_W_HI,
    PH_H_LO,
    PH_H_HI,
    PH_PLAIN,
    PH_CTL_LO,
    PH_CTL_HI,
    PH_LIT
  } rsb_phase_e;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       record_start;
  } rsb_in_t;

  typedef struct packed {
    logic [1:0]               write_kind;
    logic [OUT_ADDR_BITS-1:0] write_address;
    logic [7:0]               pixel_value;
    logic [RUN_COUNT_BITS-1:0] run_length;
    logic                     out_of_frame;
    logic                     image_done;
  } rsb_out_t;

  typedef struct packed {
    logic        transparent;
    logic [9:0]  base_row;
    logic [9:0]  base_column;
    logic [12:0] line_stride;
  } rsb_cfg_t;

  // Write operation passed from the parser to the output stage
  typedef struct packed {
    rsb_kind_e                 kind;
    logic [ADDR_BITS-1:0]      addr;
    logic [7:0]                pixel;
    logic [RUN_COUNT_BITS-1:0] len;
    logic                      done;
  } rsb_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rsb_q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rle_sprite_blitter.sv =====
// ----------------------------------------------------------------------------
// rle_sprite_blitter: streaming image-record blitter
// Parses a byte stream of plain or run-length coded image records and emits
// frame-buffer write beats.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o    in_data_i   (rsb_in_t)
//   out      out  out_valid_o / out_stall_i  out_data_o  (rsb_out_t)
//   cfg      in   cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One record byte is taken every cycle while in_stall_o is low; the parser
// touches only small counters and saturating adders per byte.
// A result beat moves from the operation queue to the register behind out_valid_o.
// The origin multiply runs in its own register stage during the header.
// Reset is asynchronous and active low; no clearing pass is needed.
// in_stall_o rises only when the operation queue holds QUEUE_DEPTH beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_sprite_blitter import rsb_pkg::*; #(
  parameter int unsigned FRAME_ADDR_BITS = FRAME_ADDR_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rsb_in_t                   in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output rsb_out_t                  out_data_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  rsb_cfg_t      cfg_q;
  rsb_q_status_t q_status;
  rsb_op_t       push_op, pop_op;
  logic          push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.transparent <= 1'b0;
      cfg_q.base_row    <= '0;
      cfg_q.base_column <= '0;
      cfg_q.line_stride <= LINE_STRIDE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TRANSPARENT: cfg_q.transparent <= cfg_wdata_i[0];
        CFG_BASE_ROW:    cfg_q.base_row    <= cfg_wdata_i[9:0];
        CFG_BASE_COLUMN: cfg_q.base_column <= cfg_wdata_i[9:0];
        CFG_LINE_STRIDE: cfg_q.line_stride <= cfg_wdata_i[12:0];
        default:         cfg_q.transparent <= cfg_q.transparent;
      endcase
    end
  end

  rsb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_status_i (q_status),
    .op_push_o  (push),
    .op_o       (push_op)
  );

  rsb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .op_i     (push_op),
    .pop_i    (pop),
    .op_o     (pop_op),
    .status_o (q_status)
  );

  rsb_back #(
    .FRAME_ADDR_BITS (FRAME_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (pop_op),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rsb_front.sv =====
// ----------------------------------------------------------------------------
// rsb_front: record parser
// Takes one record byte per cycle unless the queue is full, walks the header
// and pixel body, tracks row and pixel addresses and queues write operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rle_sprite_blitter_defines.svh"

module rsb_front import rsb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rsb_in_t       in_data_i,
  input  rsb_cfg_t      cfg_i,
  input  rsb_q_status_t q_status_i,
  output logic          op_push_o,
  output rsb_op_t       op_o
);

  rsb_phase_e           phase_q, phase_d;
  logic [7:0]           low_hold_q, low_hold_d;
  logic [1:0]           flags_q, flags_d;
  logic [15:0]          row_off_q, row_off_d;
  logic [15:0]          width_q, width_d;
  logic [15:0]          rows_left_q, rows_left_d;
  logic [15:0]          run_left_q, run_left_d;
  logic                 run_ends_q, run_ends_d;
  logic [ADDR_BITS-1:0] line_q, line_d;
  logic [ADDR_BITS-1:0] cur_q, cur_d;
  logic [16:0]          rowsum_q, rowsum_d;
  logic [16:0]          colsum_q, colsum_d;
  logic [12:0]          snap_q, snap_d;
  logic [29:0]          prod_q;

  logic                 accept, start, op_valid;
  logic [7:0]           b;
  logic [15:0]          word;
  logic [RUN_COUNT_BITS-1:0] count;
  logic                 is_run, ends, count_zero, rows_last, run_last, end_row;
  rsb_phase_e           row_phase, eol_phase;
  logic [ADDR_BITS-1:0] next_line, cur_inc, cur_cnt, origin_addr;
  logic [30:0]          origin_sum;
  rsb_op_t              op;

  function automatic logic [ADDR_BITS-1:0] sat_add(input logic [ADDR_BITS-1:0] a,
                                                   input logic [12:0] inc);
    logic [ADDR_BITS:0] s;
    s = {1'b0, a} + (ADDR_BITS+1)'(inc);
    return s[ADDR_BITS] ? ADDR_SAT : s[ADDR_BITS-1:0];
  endfunction

  // Decode the current beat
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign b          = in_data_i.record_byte;
  assign start      = in_data_i.record_start;
  assign word       = {b, low_hold_q};
  assign count      = word[RUN_COUNT_BITS-1:0];
  assign is_run     = word[CTL_RUN_BIT];
  assign ends       = word[CTL_EOL_BIT];
  assign count_zero = (count == '0);
  assign rows_last  = (rows_left_q == 16'd1);
  assign run_last   = (run_left_q == 16'd1);
  assign row_phase  = flags_q[HDR_RLE_BIT] ? PH_CTL_LO : PH_PLAIN;
  assign eol_phase  = rows_last ? PH_IDLE : row_phase;

  // Address arithmetic
  assign next_line   = sat_add(line_q, cfg_i.line_stride);
  assign cur_inc     = sat_add(cur_q, 13'd1);
  assign cur_cnt     = sat_add(cur_q, 13'(count));
  assign origin_sum  = 31'(colsum_q) + 31'(prod_q);
  assign origin_addr = (origin_sum > 31'(ADDR_SAT)) ? ADDR_SAT : origin_sum[ADDR_BITS-1:0];

  // Flag beats that close a row
  always_comb begin
    case (phase_q)
      PH_PLAIN:  end_row = run_last;
      PH_CTL_HI: end_row = ends && (is_run || count_zero);
      PH_LIT:    end_row = run_last && run_ends_q;
      default:   end_row = 1'b0;
    endcase
  end

  // Next parser phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (start) begin
        phase_d = PH_HDR_HI;
      end else begin
        case (phase_q)
          PH_IDLE:    phase_d = PH_IDLE;
          PH_HDR_HI:  phase_d = word[HDR_OFS_BIT] ? PH_ROFF_LO : PH_W_LO;
          PH_ROFF_LO: phase_d = PH_ROFF_HI;
          PH_ROFF_HI: phase_d = PH_COFF_LO;
          PH_COFF_LO: phase_d = PH_COFF_HI;
          PH_COFF_HI: phase_d = PH_W_LO;
          PH_W_LO:    phase_d = PH_W_HI;
          PH_W_HI:    phase_d = (word == '0) ? PH_IDLE : PH_H_LO;
          PH_H_LO:    phase_d = PH_H_HI;
          PH_H_HI:    phase_d = (word == '0) ? PH_IDLE : row_phase;
          PH_PLAIN:   phase_d = end_row ? eol_phase : PH_PLAIN;
          PH_CTL_LO:  phase_d = PH_CTL_HI;
          PH_CTL_HI: begin
            if (end_row) begin
              phase_d = eol_phase;
            end else if (!is_run && !count_zero) begin
              phase_d = PH_LIT;
            end else begin
              phase_d = PH_CTL_LO;
            end
          end
          PH_LIT: begin
            if (end_row) begin
              phase_d = eol_phase;
            end else if (run_last) begin
              phase_d = PH_CTL_LO;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Build the write operation for this beat
  always_comb begin
    op_valid = 1'b0;
    op.kind  = KIND_NONE;
    op.addr  = '0;
    op.pixel = '0;
    op.len   = '0;
    op.done  = end_row && rows_last;
    if (accept && !start) begin
      case (phase_q)
        PH_W_HI, PH_H_HI: begin
          op_valid = (word == '0);
          op.done  = 1'b1;
        end
        PH_PLAIN: begin
          if (!(cfg_i.transparent && b == '0)) begin
            op_valid = 1'b1;
            op.kind  = KIND_PIXEL;
            op.addr  = cur_q;
            op.pixel = b;
            op.len   = RUN_COUNT_BITS'(1);
          end else begin
            op_valid = op.done;
          end
        end
        PH_CTL_HI: begin
          if (is_run && !cfg_i.transparent && !count_zero) begin
            op_valid = 1'b1;
            op.kind  = KIND_FILL;
            op.addr  = cur_q;
            op.len   = count;
          end else begin
            op_valid = op.done;
          end
        end
        PH_LIT: begin
          op_valid = 1'b1;
          op.kind  = KIND_PIXEL;
          op.addr  = cur_q;
          op.pixel = b;
          op.len   = RUN_COUNT_BITS'(1);
        end
        default: op_valid = 1'b0;
      endcase
    end
  end

  assign op_push_o = op_valid;
  assign op_o      = op;

  // Update header fields, counters and addresses
  always_comb begin
    low_hold_d  = low_hold_q;
    flags_d     = flags_q;
    row_off_d   = row_off_q;
    width_d     = width_q;
    rows_left_d = rows_left_q;
    run_left_d  = run_left_q;
    run_ends_d  = run_ends_q;
    line_d      = line_q;
    cur_d       = cur_q;
    rowsum_d    = rowsum_q;
    colsum_d    = colsum_q;
    snap_d      = snap_q;
    if (accept) begin
      if (start) begin
        low_hold_d = b;
      end else begin
        case (phase_q)
          PH_HDR_HI: begin
            flags_d   = word[1:0];
            row_off_d = '0;
            // Latch the origin terms; the product settles before the body
            if (!word[HDR_OFS_BIT]) begin
              rowsum_d = 17'(cfg_i.base_row);
              colsum_d = 17'(cfg_i.base_column);
              snap_d   = cfg_i.line_stride;
            end
          end
          PH_ROFF_LO, PH_COFF_LO, PH_W_LO, PH_H_LO, PH_CTL_LO: low_hold_d = b;
          PH_ROFF_HI: row_off_d = word;
          PH_COFF_HI: begin
            rowsum_d = 17'(cfg_i.base_row) + 17'(row_off_q);
            colsum_d = 17'(cfg_i.base_column) + 17'(word);
            snap_d   = cfg_i.line_stride;
          end
          PH_W_HI: width_d = word;
          PH_H_HI: begin
            rows_left_d = word;
            line_d      = origin_addr;
            cur_d       = origin_addr;
            if (!flags_q[HDR_RLE_BIT]) begin
              run_left_d = width_q;
            end
          end
          PH_PLAIN, PH_LIT: begin
            cur_d      = cur_inc;
            run_left_d = run_left_q - 16'd1;
          end
          PH_CTL_HI: begin
            if (is_run) begin
              cur_d = cur_cnt;
            end else if (!count_zero) begin
              run_left_d = 16'(count);
              run_ends_d = ends;
            end
          end
          default: low_hold_d = low_hold_q;
        endcase
        // Step to the next row
        if (end_row) begin
          line_d      = next_line;
          cur_d       = next_line;
          rows_left_d = rows_left_q - 16'd1;
          if (!flags_q[HDR_RLE_BIT]) begin
            run_left_d = width_q;
          end
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      flags_q     <= '0;
      rows_left_q <= '0;
      run_left_q  <= '0;
      run_ends_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      flags_q     <= flags_d;
      rows_left_q <= rows_left_d;
      run_left_q  <= run_left_d;
      run_ends_q  <= run_ends_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    low_hold_q <= low_hold_d;
    row_off_q  <= row_off_d;
    width_q    <= width_d;
    line_q     <= line_d;
    cur_q      <= cur_d;
    rowsum_q   <= rowsum_d;
    colsum_q   <= colsum_d;
    snap_q     <= snap_d;
    prod_q     <= 30'(snap_q) * 30'(rowsum_q);
  end

  `RSB_ASSERT_NXT(a_done_goes_idle, clk_i, rst_ni, op_push_o && op_o.done, phase_q == PH_IDLE)
  `RSB_ASSERT_IMP(a_none_carries_done, clk_i, rst_ni, op_push_o && op_o.kind == KIND_NONE, op_o.done)
  `RSB_ASSERT_IMP(a_run_nonzero, clk_i, rst_ni, phase_q == PH_PLAIN || phase_q == PH_LIT, run_left_q != '0)

endmodule

`default_nettype wire

// ===== hw/rtl/rsb_queue.sv =====
// ----------------------------------------------------------------------------
// rsb_queue: operation queue
// Short FIFO between the parser and the output stage so each side can
// stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rle_sprite_blitter_defines.svh"

module rsb_queue import rsb_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rsb_op_t       op_i,
  input  logic          pop_i,
  output rsb_op_t       op_o,
  output rsb_q_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rsb_op_t            slots_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed beats
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= op_i;
    end
  end

  assign op_o           = slots_q[rd_ptr_q];
  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);

  `RSB_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))
  `RSB_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push_i, !status_o.full)
  `RSB_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, !status_o.empty)

endmodule

`default_nettype wire

// ===== hw/rtl/rsb_back.sv =====
// ----------------------------------------------------------------------------
// rsb_back: output stage
// Pops write operations, checks them against the frame size, masks the
// address and holds the result beat in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsb_back import rsb_pkg::*; #(
  parameter int unsigned FRAME_ADDR_BITS = FRAME_ADDR_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsb_op_t       op_i,
  input  rsb_q_status_t q_status_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rsb_out_t      out_data_o
);

  localparam logic [ADDR_BITS:0]   FRAME_SIZE = (ADDR_BITS+1)'(1) << FRAME_ADDR_BITS;
  localparam logic [ADDR_BITS-1:0] ADDR_MASK  = ADDR_BITS'(FRAME_SIZE - (ADDR_BITS+1)'(1));

  logic                 out_valid_q, out_valid_d, load;
  rsb_out_t             out_q, out_d;
  logic [ADDR_BITS-1:0] addr_masked;
  logic [ADDR_BITS:0]   reach;

  // Load when the register is empty or its beat is taken
  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = load && !q_status_i.empty;

  // Format the result beat
  always_comb begin
    addr_masked         = op_i.addr & ADDR_MASK;
    reach               = (ADDR_BITS+1)'(op_i.addr) + (ADDR_BITS+1)'(op_i.len);
    out_d.write_kind    = op_i.kind;
    out_d.write_address = addr_masked[OUT_ADDR_BITS-1:0];
    out_d.pixel_value   = op_i.pixel;
    out_d.run_length    = op_i.len;
    out_d.out_of_frame  = (op_i.kind != KIND_NONE) && (reach > FRAME_SIZE);
    out_d.image_done    = op_i.done;
    out_valid_d         = load ? !q_status_i.empty : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
